// ===== hw/rtl/rpup_pkg.sv =====
// ----------------------------------------------------------------------------
// rpup_pkg
// Shared types and character constants for the radix-prefixed number parser.
// ----------------------------------------------------------------------------
package rpup_pkg;

  // Where the parser stands within one number.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  localparam logic [4:0] RADIX_2  = 5'd2;
  localparam logic [4:0] RADIX_8  = 5'd8;
  localparam logic [4:0] RADIX_10 = 5'd10;
  localparam logic [4:0] RADIX_16 = 5'd16;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_O    = 8'h6F;
  localparam logic [7:0] CH_B    = 8'h62;

  // Case bit of an ASCII letter, and the gap between '9'+1 and 'A'.
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] ALPHA_GAP  = 8'd7;
  localparam logic [7:0] ALPHA_BASE = 8'd17;

  // What the step logic hands back for one processed character.
  typedef struct packed {
    logic        emit;
    logic [31:0] number;
  } step_t;

endpackage

// ===== hw/rtl/rpup_digit.sv =====
// ----------------------------------------------------------------------------
// rpup_digit
// Maps a character byte to its digit value and checks it against the radix.
// ----------------------------------------------------------------------------
module rpup_digit
  import rpup_pkg::*;
(
  input  logic [7:0] ch,
  input  logic [4:0] radix,
  output logic       is_digit,
  output logic [3:0] digit
);

  logic [8:0] diff;
  logic [7:0] folded;
  logic [7:0] mapped;
  logic       in_map;

  assign diff   = {1'b0, ch} - {1'b0, CH_ZERO};
  assign folded = diff[7:0] & ~CASE_BIT;

  // Bytes below '0' wrap to huge values, as do the folded letters that
  // land below the alphabetic gap; neither can ever be a digit.
  always_comb begin
    in_map = 1'b1;
    mapped = diff[7:0];
    if (diff[8]) begin
      in_map = 1'b0;
    end else if (diff[7:0] >= ALPHA_BASE) begin
      if (folded < ALPHA_GAP) begin
        in_map = 1'b0;
      end else begin
        mapped = folded - ALPHA_GAP;
      end
    end
  end

  assign is_digit = in_map && (mapped < {3'b000, radix});
  assign digit    = mapped[3:0];

endmodule

// ===== hw/rtl/rpup_core.sv =====
// ----------------------------------------------------------------------------
// rpup_core
// Parser state and the combinational update for one character.
// ----------------------------------------------------------------------------
module rpup_core
  import rpup_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] ch,
  output step_t      step
);

  phase_t      phase, phase_next;
  logic [4:0]  radix, radix_next;
  logic [31:0] acc, acc_next;

  logic [4:0]  eff_radix;
  logic [31:0] eff_acc;
  logic [31:0] scaled;
  logic        take;
  logic        is_digit;
  logic [3:0]  digit;

  rpup_digit u_digit (
    .ch       (ch),
    .radix    (eff_radix),
    .is_digit (is_digit),
    .digit    (digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      radix <= RADIX_10;
      acc   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      radix <= radix_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    case (eff_radix)
      RADIX_16: scaled = {eff_acc[27:0], 4'b0000};
      RADIX_8:  scaled = {eff_acc[28:0], 3'b000};
      RADIX_2:  scaled = {eff_acc[30:0], 1'b0};
      default:  scaled = {eff_acc[28:0], 3'b000} + {eff_acc[30:0], 1'b0};
    endcase
  end

  always_comb begin
    phase_next  = phase;
    radix_next  = radix;
    acc_next    = acc;
    eff_radix   = radix;
    eff_acc     = acc;
    take        = 1'b0;
    step.emit   = 1'b0;
    step.number = acc;

    case (phase)
      PH_START: begin
        if (ch == CH_PLUS) begin
          phase_next = PH_SIGNED;
        end else if (ch == CH_ZERO) begin
          phase_next = PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (ch == CH_ZERO) begin
          phase_next = PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      PH_ZERO: begin
        if (ch == CH_X || ch == CH_O || ch == CH_B) begin
          radix_next = (ch == CH_X) ? RADIX_16 : (ch == CH_O) ? RADIX_8 : RADIX_2;
          acc_next   = '0;
          phase_next = PH_DIGITS;
        end else begin
          // The leading zero was an ordinary decimal digit.
          eff_radix = RADIX_10;
          eff_acc   = '0;
          take      = 1'b1;
        end
      end
      default: begin
        take = 1'b1;
      end
    endcase

    if (take) begin
      if (is_digit) begin
        acc_next   = scaled + {28'd0, digit};
        radix_next = eff_radix;
        phase_next = PH_DIGITS;
      end else begin
        step.emit   = 1'b1;
        step.number = eff_acc;
        phase_next  = PH_START;
        radix_next  = RADIX_10;
        acc_next    = '0;
      end
    end
  end

endmodule

// ===== hw/rtl/radix_prefixed_uint_parser_top.sv =====
// ----------------------------------------------------------------------------
// radix_prefixed_uint_parser_top
// Streaming parser that turns ASCII characters into unsigned 32-bit numbers.
// ----------------------------------------------------------------------------
// The slave channel takes one character per beat in s_tdata. An optional
// leading '+' is skipped, and a leading '0' followed by 'x', 'o' or 'b'
// selects hexadecimal, octal or binary; otherwise the number is decimal.
// The first byte that is not a digit of the active radix ends the number:
// that byte is consumed and the value, wrapped to 32 bits, leaves on the
// master channel as one beat. Characters that do not end a number give
// no output beat.
// Each accepted character sits in an input register and is processed by the
// state update once the output register can take its result, which is then
// loaded into the output register, so a terminating character passes the
// input register and the output register before it shows up on m_tvalid.
// While the receiver keeps up, one character is taken every cycle; the loop
// that sets this figure is the parser state register with its update logic.
// When the receiver stalls, a pending result stays in the output register.
// The input register, if empty, still takes one more character, but it is
// not processed, whether it ends a number or not, until the output register
// is free, so s_tready stays low from then on until the pending beat leaves.
// Reset is synchronous and returns the parser to its start state, radix
// ten and a zero value, and empties both registers.
// ----------------------------------------------------------------------------
module radix_prefixed_uint_parser_top
  import rpup_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] number
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       fire;
  step_t      step;

  // The held character is processed whenever the output register can take
  // whatever it might produce.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  rpup_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (in_char),
    .step (step)
  );

  // Output register: loaded by a terminating character, emptied by a beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && step.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      m_tdata <= step.number;
    end
  end

  // An empty output register never holds back the input side.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  // A character taken in is held for processing in the next cycle.
  a_beat_captured : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted character lost before processing");

  // A held character is processed at once when nothing is waiting downstream.
  a_process_when_free : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !m_tvalid) |-> fire)
    else $error("held character not processed with a free output register");

  // Reset leaves no result pending.
  a_reset_empties : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix-prefixed unsigned number parser.
// ----------------------------------------------------------------------------
// Characters are driven one beat at a time into the slave channel. Each
// accepted character is fed to a local copy of the parser, which decides
// whether the byte ends a number and what value should leave the block.
// Expected numbers wait in a queue, and every beat on the master channel is
// checked against the oldest one. A short table of hand-picked characters
// comes first; a few of its rows carry the value typed in. Random text then
// follows: mostly well-formed numbers in all four radixes with random
// content, plus noise and broken numbers. Both channels idle at random,
// with one stretch that runs flat out. The receiver also holds off once for
// a long time so that the block fills up and stalls its input, and once the
// sender pauses until every expected number has come back.
// ----------------------------------------------------------------------------
module tb;
  import rpup_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 300;   // length of the long receiver hold-off
  localparam int DRAIN_CYCLES = 10;    // two-stage pipeline plus some margin
  localparam int RANDOM_CHARS = 1800;

  // One row of the directed table. Where known is set the number that the
  // row ends is typed in rather than taken from the local parser.
  typedef struct packed {
    logic [7:0]  ch;
    logic        known;
    logic [31:0] num;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // Largest value the block can return: 0xFFFFFFFF, ended by a space.
    '{CH_ZERO, 1'b0, 32'd0}, '{CH_X, 1'b0, 32'd0},
    '{"F", 1'b0, 32'd0}, '{"F", 1'b0, 32'd0}, '{"F", 1'b0, 32'd0},
    '{"F", 1'b0, 32'd0}, '{"f", 1'b0, 32'd0}, '{"f", 1'b0, 32'd0},
    '{"f", 1'b0, 32'd0}, '{"f", 1'b0, 32'd0}, '{" ", 1'b1, 32'hFFFF_FFFF},
    // Empty number: the lowest byte ends it at once.
    '{8'h00, 1'b1, 32'd0},
    // Binary, ended by the highest byte.
    '{CH_ZERO, 1'b0, 32'd0}, '{CH_B, 1'b0, 32'd0}, '{"1", 1'b0, 32'd0},
    '{8'hFF, 1'b1, 32'd1},
    // A second plus sign is just another terminator.
    '{CH_PLUS, 1'b0, 32'd0}, '{CH_PLUS, 1'b1, 32'd0},
    // Octal prefix with no digits behind it.
    '{CH_ZERO, 1'b0, 32'd0}, '{CH_O, 1'b0, 32'd0}, '{CH_PLUS, 1'b1, 32'd0},
    // In hexadecimal the colon counts as ten; 'g' falls out of range.
    '{CH_ZERO, 1'b0, 32'd0}, '{CH_X, 1'b0, 32'd0}, '{":", 1'b0, 32'd0},
    '{"g", 1'b0, 32'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_code
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] number

  // Local copy of the parser state.
  phase_t      prs_phase;
  logic [4:0]  prs_radix;
  logic [31:0] prs_value;

  logic [31:0] expected_numbers [$];
  int          fail_count;
  int          chars_sent;
  int          src_idle_pct;
  int          sink_idle_pct;
  bit          want_hold;
  int          quiet_cycles;

  radix_prefixed_uint_parser_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Digit value of a byte with the parser's own folding: anything from 17
  // up loses its case bit and drops by the gap between '9'+1 and 'A', all in
  // 32-bit wrapping arithmetic, so bytes below '0' come out huge.
  function automatic logic [31:0] digit_of(input logic [7:0] ch);
    logic [31:0] d;
    d = {24'd0, ch} - {24'd0, CH_ZERO};
    if (d >= {24'd0, ALPHA_BASE}) begin
      d = (d & ~{24'd0, CASE_BIT}) - {24'd0, ALPHA_GAP};
    end
    return d;
  endfunction

  // Back to the start: no sign, radix ten, nothing accumulated.
  task automatic parser_restart();
    prs_phase = PH_START;
    prs_radix = RADIX_10;
    prs_value = 32'd0;
  endtask

  // Digit body: either extend the value or end the number with this byte.
  task automatic take_digit(input logic [7:0] ch, output bit emit,
                            output logic [31:0] num);
    logic [31:0] d;
    d = digit_of(ch);
    emit = 1'b0;
    num  = 32'd0;
    if (d >= {27'd0, prs_radix}) begin
      emit = 1'b1;
      num  = prs_value;
      parser_restart();
    end else begin
      prs_value = prs_value * {27'd0, prs_radix} + d;
      prs_phase = PH_DIGITS;
    end
  endtask

  // Advance the local parser by one accepted character.
  task automatic parse_char(input logic [7:0] ch, output bit emit,
                            output logic [31:0] num);
    emit = 1'b0;
    num  = 32'd0;
    case (prs_phase)
      PH_START: begin
        if (ch == CH_PLUS) prs_phase = PH_SIGNED;
        else if (ch == CH_ZERO) prs_phase = PH_ZERO;
        else take_digit(ch, emit, num);
      end
      PH_SIGNED: begin
        if (ch == CH_ZERO) prs_phase = PH_ZERO;
        else take_digit(ch, emit, num);
      end
      PH_ZERO: begin
        // A prefix letter counts only straight after the leading zero.
        prs_value = 32'd0;
        if (ch == CH_X) begin
          prs_radix = RADIX_16;
          prs_phase = PH_DIGITS;
        end else if (ch == CH_O) begin
          prs_radix = RADIX_8;
          prs_phase = PH_DIGITS;
        end else if (ch == CH_B) begin
          prs_radix = RADIX_2;
          prs_phase = PH_DIGITS;
        end else begin
          // The leading zero was an ordinary decimal digit worth nothing.
          prs_radix = RADIX_10;
          take_digit(ch, emit, num);
        end
      end
      default: take_digit(ch, emit, num);
    endcase
  endtask

  // Offers one character, keeping tvalid high across back-to-back beats,
  // and books the expected number once the beat is taken. Entered and left
  // on a falling edge.
  task automatic send_char(input logic [7:0] ch, input bit known,
                           input logic [31:0] known_num);
    bit          emit;
    logic [31:0] num;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_char(ch, emit, num);
    if (emit) expected_numbers.push_back(known ? known_num : num);
    chars_sent++;
    @(negedge clk);
  endtask

  // A random digit of the given radix. Hex digits above nine appear in
  // upper case, lower case, or as the punctuation that folds onto them.
  function automatic logic [7:0] digit_char(input logic [4:0] radix);
    int v;
    v = $urandom_range(int'(radix) - 1);
    if (v < 10) return CH_ZERO + 8'(v);
    case ($urandom_range(2))
      0:       return 8'h3A + 8'(v - 10);   // ':' and the five after it
      1:       return 8'h41 + 8'(v - 10);   // 'A'..'F'
      default: return 8'h61 + 8'(v - 10);   // 'a'..'f'
    endcase
  endfunction

  // One well-formed number with random content, now and then broken by a
  // stray byte, and ended by a random byte. The terminator may itself turn
  // out to be a digit, in which case the number simply runs on.
  task automatic send_number();
    int         sel;
    int         ndig;
    logic [4:0] radix;
    if ($urandom_range(3) == 0) send_char(CH_PLUS, 1'b0, 32'd0);
    sel = $urandom_range(4);
    case (sel)
      0: begin
        radix = RADIX_16;
        send_char(CH_ZERO, 1'b0, 32'd0);
        send_char(CH_X, 1'b0, 32'd0);
      end
      1: begin
        radix = RADIX_8;
        send_char(CH_ZERO, 1'b0, 32'd0);
        send_char(CH_O, 1'b0, 32'd0);
      end
      2: begin
        radix = RADIX_2;
        send_char(CH_ZERO, 1'b0, 32'd0);
        send_char(CH_B, 1'b0, 32'd0);
      end
      default: radix = RADIX_10;
    endcase
    // Mostly short numbers; about one in ten runs long, from 11 to 40 digits.
    ndig = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10);
    if (ndig == 0 && sel < 3) ndig = $urandom_range(1);
    for (int i = 0; i < ndig; i++) begin
      if ($urandom_range(49) == 0) send_char(8'($urandom_range(255)), 1'b0, 32'd0);
      else send_char(digit_char(radix), 1'b0, 32'd0);
    end
    case ($urandom_range(3))
      0:       send_char(" ", 1'b0, 32'd0);
      1:       send_char(",", 1'b0, 32'd0);
      default: send_char(8'($urandom_range(255)), 1'b0, 32'd0);
    endcase
  endtask

  // Receiver: random back-pressure, plus one long hold-off that it times
  // itself once asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= sink_idle_pct);
      end
      @(negedge clk);
    end
  end

  // Output check and watchdog. Both look only at values sampled on the
  // rising edge.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (m_tvalid && m_tready) begin
        if (expected_numbers.size() == 0) begin
          $error("number: expected nothing, got %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_numbers.pop_front();
          if (m_tdata !== want) begin
            $error("number: expected %h, got %h", want, m_tdata);
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** radix_prefixed_uint_parser_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int target;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'd0;
    fail_count    = 0;
    chars_sent    = 0;
    quiet_cycles  = 0;
    want_hold     = 1'b0;
    src_idle_pct  = 33;
    sink_idle_pct = 33;
    parser_restart();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (DIRECTED_ROWS[i]) begin
      send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].num);
    end

    // Random text in three stretches. The first opens with the long
    // receiver hold-off while characters keep coming, and ends with the
    // sender waiting for every number to come back. The second runs with
    // no idling on either side. The third returns to random idling.
    for (int stretch = 0; stretch < 3; stretch++) begin
      src_idle_pct  = (stretch == 1) ? 0 : 33;
      sink_idle_pct = (stretch == 1) ? 0 : 33;
      if (stretch == 0) want_hold = 1'b1;
      target = chars_sent + RANDOM_CHARS / 3;
      while (chars_sent < target) begin
        if ($urandom_range(99) < 80) begin
          send_number();
        end else begin
          repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)), 1'b0, 32'd0);
        end
      end
      if (stretch == 0) begin
        s_tvalid = 1'b0;
        while (expected_numbers.size() != 0) @(negedge clk);
      end
    end

    // Drain: the watchdog catches numbers that never arrive.
    s_tvalid = 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** radix_prefixed_uint_parser_top: PASSED **");
    end else begin
      $display("** radix_prefixed_uint_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
